FILE: src/bcf_pkg.sv
// Package for the Bezier curve flattener: coordinate width, segment limit,
// request and point transaction structs, and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package bcf_pkg;

    localparam int COORD_BITS   = 24;
    localparam int MAX_SEGMENTS = 63;
    localparam int SEG_BITS     = 6;
    localparam int T_BITS       = 17;  // t and u hold 1.0 exactly
    localparam int W_BITS       = 33;  // Q0.32 weight, holds 1.0 exactly

    localparam logic CMD_QUAD  = 1'b0;
    localparam logic CMD_CUBIC = 1'b1;

    typedef struct packed {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] ctrl1_x;
        logic signed [COORD_BITS-1:0] ctrl1_y;
        logic signed [COORD_BITS-1:0] ctrl2_x;
        logic signed [COORD_BITS-1:0] ctrl2_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [SEG_BITS-1:0]   segment_count;
    } t_bcf_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic        [SEG_BITS-1:0]   point_index;
        logic                         last;
    } t_bcf_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DRAIN
    } t_bcf_state;

endpackage

FILE: src/bezier_curve_flattener.sv
// Top level of the Bezier curve flattener: sequencer, step divider and the
// five-stage weight and blend pipeline. Depends on bcf_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_req   (bcf_pkg::t_bcf_in)
// point     out        o_strobe, one cycle each  o_point (bcf_pkg::t_bcf_out)
//
// A request first forms the parameter step 65536/N (one quotient bit per cycle
// in a restoring divider; skipped when N is zero), then issues its N+1 points
// one point a cycle, then waits while the pipeline drains. busy stays high
// from acceptance until the last point has left. Reset is synchronous, active
// low, and clears the sequencer and all valid bits. The receiver cannot stall:
// each point transaction is shown for exactly one cycle.
module bezier_curve_flattener (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bcf_pkg::t_bcf_in  i_req,
    output logic              o_strobe,
    output bcf_pkg::t_bcf_out o_point
);
    import bcf_pkg::*;

    localparam int M_BITS = 2 * T_BITS;          // u*u, u*t, t*t
    localparam int E_BITS = M_BITS + T_BITS + 2; // 3 * (u*u) * t
    localparam int P_BITS = COORD_BITS + W_BITS + 1;
    localparam int S_BITS = P_BITS + 2;
    localparam int Q_BITS = S_BITS - 32;

    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << 16;
    localparam logic [W_BITS-1:0] W_ONE = W_BITS'(1) << 32;
    localparam logic [4:0]        DIV_TOP = 5'd16;

    // Sequencer and request registers.
    t_bcf_state r_state, n_state;
    t_bcf_in    r_req;
    logic [SEG_BITS-1:0] r_n;
    logic [SEG_BITS-1:0] r_idx;
    logic [T_BITS-1:0]   r_q;        // current t
    logic [SEG_BITS-1:0] r_r;        // remainder of t
    logic [T_BITS-1:0]   r_sq;       // step quotient 65536 / N
    logic [SEG_BITS-1:0] r_rem;      // step remainder 65536 % N
    logic [4:0]          r_cnt;

    logic accept, issue, issue_last, drain_done;
    logic [SEG_BITS-1:0] seg_sat;
    logic [SEG_BITS:0]   rem_sh, rem_sub, rem_acc, rem_fold;
    logic                rem_ge, rem_carry;

    // Pipeline valid bits for stages A through D.
    logic [3:0] r_vld;

    assign accept     = start && !busy;
    assign issue_last = (r_idx == r_n);
    assign drain_done = (r_vld == 4'd0) && !o_strobe;
    assign seg_sat    = (i_req.segment_count > SEG_BITS'(MAX_SEGMENTS)) ?
                        SEG_BITS'(MAX_SEGMENTS) : i_req.segment_count;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (seg_sat == '0) ? ST_RUN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        busy  = 1'b1;
        issue = 1'b0;
        case (r_state)
            ST_IDLE:  busy  = 1'b0;
            ST_RUN:   issue = 1'b1;
            default:  busy  = 1'b1;
        endcase
    end

    // One restoring division step: the dividend 65536 has its only one bit
    // at the top, so the shifted-in bit is set on the first step alone.
    assign rem_sh  = {r_rem, (r_cnt == DIV_TOP)};
    assign rem_ge  = (rem_sh >= {1'b0, r_n});
    assign rem_sub = rem_ge ? (rem_sh - {1'b0, r_n}) : rem_sh;

    // Exact t = round(i*65536/N): add the step and fold the remainder once.
    assign rem_acc   = {1'b0, r_r} + {1'b0, r_rem};
    assign rem_carry = (rem_acc >= {1'b0, r_n});
    assign rem_fold  = rem_carry ? (rem_acc - {1'b0, r_n}) : rem_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_n   <= seg_sat;
            r_idx <= '0;
            r_q   <= (seg_sat == '0) ? T_ONE : '0;
            r_r   <= seg_sat >> 1;
            r_rem <= '0;
            r_sq  <= '0;
            r_cnt <= DIV_TOP;
        end else if (r_state == ST_DIV) begin
            r_rem <= rem_sub[SEG_BITS-1:0];
            r_sq  <= {r_sq[T_BITS-2:0], rem_ge};
            r_cnt <= r_cnt - 5'd1;
        end else if (issue && !issue_last) begin
            r_idx <= r_idx + SEG_BITS'(1);
            r_q   <= r_q + r_sq + T_BITS'(rem_carry);
            r_r   <= rem_fold[SEG_BITS-1:0];
        end
    end

    // Stage A: squares and cross product of u and t.
    logic [T_BITS-1:0]   u_cur;
    logic [M_BITS-1:0]   r_a_uu, r_a_ut, r_a_tt;
    logic [T_BITS-1:0]   r_a_t;
    logic [SEG_BITS-1:0] r_a_idx, r_b_idx, r_c_idx, r_d_idx;
    logic                r_a_last, r_b_last, r_c_last, r_d_last;
    logic                r_a_cub, r_b_cub;

    assign u_cur = T_ONE - r_q;

    always_ff @(posedge i_clk) begin
        r_a_uu   <= u_cur * u_cur;
        r_a_ut   <= u_cur * r_q;
        r_a_tt   <= r_q * r_q;
        r_a_t    <= r_q;
        r_a_idx  <= r_idx;
        r_a_last <= issue_last;
        r_a_cub  <= r_req.cmd;
    end

    // Stage B: cubic products of Q0.48 and the exact quadratic weights.
    logic [E_BITS-1:0] m_uut, m_utt;
    logic [E_BITS-1:0] r_b_e1, r_b_e2, r_b_e3;
    logic [W_BITS-1:0] r_b_q0, r_b_q1, r_b_q2;

    assign m_uut = E_BITS'(r_a_uu * r_a_t);
    assign m_utt = E_BITS'(r_a_ut * r_a_t);

    always_ff @(posedge i_clk) begin
        r_b_e1   <= m_uut + (m_uut << 1);
        r_b_e2   <= m_utt + (m_utt << 1);
        r_b_e3   <= E_BITS'(r_a_tt * r_a_t);
        r_b_q0   <= r_a_uu[W_BITS-1:0];
        r_b_q1   <= {r_a_ut[W_BITS-2:0], 1'b0};
        r_b_q2   <= r_a_tt[W_BITS-1:0];
        r_b_idx  <= r_a_idx;
        r_b_last <= r_a_last;
        r_b_cub  <= r_a_cub;
    end

    // Stage C: round the cubic weights to Q0.32, make the start weight the
    // complement so the four sum to one, and lay weights on the four points.
    logic [E_BITS-1:0] e1_rnd, e2_rnd, e3_rnd;
    logic [W_BITS-1:0] w1c, w2c, w3c;
    logic [W_BITS-1:0] r_c_w [4];

    assign e1_rnd = (r_b_e1 + E_BITS'(32768)) >> 16;
    assign e2_rnd = (r_b_e2 + E_BITS'(32768)) >> 16;
    assign e3_rnd = (r_b_e3 + E_BITS'(32768)) >> 16;
    assign w1c    = e1_rnd[W_BITS-1:0];
    assign w2c    = e2_rnd[W_BITS-1:0];
    assign w3c    = e3_rnd[W_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (r_b_cub == CMD_CUBIC) begin
            r_c_w[0] <= W_ONE - w1c - w2c - w3c;
            r_c_w[1] <= w1c;
            r_c_w[2] <= w2c;
            r_c_w[3] <= w3c;
        end else begin
            // Quadratic: the second control point gets no weight.
            r_c_w[0] <= r_b_q0;
            r_c_w[1] <= r_b_q1;
            r_c_w[2] <= '0;
            r_c_w[3] <= r_b_q2;
        end
        r_c_idx  <= r_b_idx;
        r_c_last <= r_b_last;
    end

    // Stage D: weight times coordinate for each of the eight terms.
    logic signed [COORD_BITS-1:0] pt_x [4];
    logic signed [COORD_BITS-1:0] pt_y [4];
    logic signed [P_BITS-1:0]     r_d_px [4];
    logic signed [P_BITS-1:0]     r_d_py [4];

    assign pt_x[0] = r_req.start_x;
    assign pt_x[1] = r_req.ctrl1_x;
    assign pt_x[2] = r_req.ctrl2_x;
    assign pt_x[3] = r_req.end_x;
    assign pt_y[0] = r_req.start_y;
    assign pt_y[1] = r_req.ctrl1_y;
    assign pt_y[2] = r_req.ctrl2_y;
    assign pt_y[3] = r_req.end_y;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_d_px[k] <= P_BITS'($signed({1'b0, r_c_w[k]}) * pt_x[k]);
            r_d_py[k] <= P_BITS'($signed({1'b0, r_c_w[k]}) * pt_y[k]);
        end
        r_d_idx  <= r_c_idx;
        r_d_last <= r_c_last;
    end

    // Stage E: sum, round half up, drop 32 fraction bits, saturate.
    logic signed [S_BITS-1:0]     sum_x, sum_y;
    logic signed [Q_BITS-1:0]     qx, qy;
    logic signed [COORD_BITS-1:0] sat_x, sat_y;

    localparam logic signed [Q_BITS-1:0] C_MAX =
        Q_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_BITS-1:0] C_MIN = -C_MAX - Q_BITS'(1);

    always_comb begin
        sum_x = S_BITS'(r_d_px[0]) + S_BITS'(r_d_px[1]) + S_BITS'(r_d_px[2])
              + S_BITS'(r_d_px[3]) + (S_BITS'(1) <<< 31);
        sum_y = S_BITS'(r_d_py[0]) + S_BITS'(r_d_py[1]) + S_BITS'(r_d_py[2])
              + S_BITS'(r_d_py[3]) + (S_BITS'(1) <<< 31);
        qx    = sum_x[S_BITS-1:32];
        qy    = sum_y[S_BITS-1:32];
        sat_x = (qx > C_MAX) ? C_MAX[COORD_BITS-1:0] :
                (qx < C_MIN) ? C_MIN[COORD_BITS-1:0] : qx[COORD_BITS-1:0];
        sat_y = (qy > C_MAX) ? C_MAX[COORD_BITS-1:0] :
                (qy < C_MIN) ? C_MIN[COORD_BITS-1:0] : qy[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_point.point_x     <= sat_x;
        o_point.point_y     <= sat_y;
        o_point.point_index <= r_d_idx;
        o_point.last        <= r_d_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[2:0], issue};
            o_strobe <= r_vld[3];
        end
    end

`ifndef SYNTH
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_vld == 4'd0 && !o_strobe))
        else $error("pipeline holds points while the flattener is idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy did not rise after a request was accepted");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point.last) |=> !o_strobe)
        else $error("point emitted after the end point of a request");

    a_issue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !issue_last) |=> (issue && r_idx == $past(r_idx) + SEG_BITS'(1)))
        else $error("point index did not advance by one while issuing");
`endif

endmodule

FILE: tb/sv/bezier_curve_flattener_test.sv
// Self-checking testbench for the Bezier curve flattener: drives curve requests,
// predicts every emitted point in a scoreboard class and checks each one.
// Depends on bcf_pkg and bezier_curve_flattener.
`timescale 1ns / 1ps

// Holds the points that accepted curve requests should produce, oldest first,
// and compares each emitted point against them.
class curve_point_board;
    bcf_pkg::t_bcf_out pending[$];
    int errors;
    int points_checked;

    function new();
        errors = 0;
        points_checked = 0;
    endfunction

    // Weighted blend of up to four coordinates with Q0.32 weights, rounded to
    // nearest with halves up, then saturated to the coordinate range.
    function automatic logic signed [23:0] blend(longint unsigned w0, longint unsigned w1,
                                                 longint unsigned w2, longint unsigned w3,
                                                 longint p0, longint p1,
                                                 longint p2, longint p3);
        logic signed [95:0] acc;
        logic signed [95:0] q;
        acc = $signed({32'd0, w0}) * p0 + $signed({32'd0, w1}) * p1
            + $signed({32'd0, w2}) * p2 + $signed({32'd0, w3}) * p3;
        acc = acc + (96'sd1 <<< 31);
        q = acc >>> 32;
        if (q > 96'sd8388607) q = 96'sd8388607;
        if (q < -96'sd8388608) q = -96'sd8388608;
        return q[23:0];
    endfunction

    // Work out every point of one accepted request.
    function void note_request(bcf_pkg::t_bcf_in rq);
        longint px[4];
        longint py[4];
        longint unsigned n, t, u, w0, w1, w2, w3;
        bcf_pkg::t_bcf_out pt;
        bit cubic;
        cubic = (rq.cmd == bcf_pkg::CMD_CUBIC);
        px[0] = rq.start_x; py[0] = rq.start_y;
        px[1] = rq.ctrl1_x; py[1] = rq.ctrl1_y;
        if (cubic) begin
            px[2] = rq.ctrl2_x; py[2] = rq.ctrl2_y;
            px[3] = rq.end_x;   py[3] = rq.end_y;
        end else begin
            px[2] = rq.end_x;   py[2] = rq.end_y;
            px[3] = 0;          py[3] = 0;
        end
        n = rq.segment_count;
        if (n > bcf_pkg::MAX_SEGMENTS) n = bcf_pkg::MAX_SEGMENTS;
        for (longint unsigned i = 0; i < n; i++) begin
            t = ((i << 16) + (n >> 1)) / n;
            u = 65536 - t;
            if (cubic) begin
                w1 = (3 * u * u * t + 32768) >> 16;
                w2 = (3 * u * t * t + 32768) >> 16;
                w3 = (t * t * t + 32768) >> 16;
                w0 = (64'd1 << 32) - w1 - w2 - w3;
            end else begin
                w0 = u * u;
                w1 = 2 * u * t;
                w2 = t * t;
                w3 = 0;
            end
            pt.point_x = blend(w0, w1, w2, w3, px[0], px[1], px[2], px[3]);
            pt.point_y = blend(w0, w1, w2, w3, py[0], py[1], py[2], py[3]);
            pt.point_index = i[5:0];
            pt.last = 1'b0;
            pending.insert(pending.size(), pt);
        end
        // The exact end point always closes the run.
        pt.point_x = rq.end_x;
        pt.point_y = rq.end_y;
        pt.point_index = n[5:0];
        pt.last = 1'b1;
        pending.insert(pending.size(), pt);
    endfunction

    function void check_point(bcf_pkg::t_bcf_out got);
        bcf_pkg::t_bcf_out want;
        if (pending.size() == 0) begin
            $error("point emitted with nothing pending: x=%0d y=%0d idx=%0d",
                   got.point_x, got.point_y, got.point_index);
            errors++;
            return;
        end
        want = pending.pop_front();
        points_checked++;
        if (got.point_x !== want.point_x) begin
            $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
            errors++;
        end
        if (got.point_y !== want.point_y) begin
            $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
            errors++;
        end
        if (got.point_index !== want.point_index) begin
            $error("point_index: expected %0d, actual %0d", want.point_index,
                   got.point_index);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module bezier_curve_flattener_test;
    import bcf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_bcf_in i_req = '0;
    logic o_strobe;
    t_bcf_out o_point;

    curve_point_board board = new();
    int requests_sent = 0;
    int quad_sent = 0;
    int cubic_sent = 0;
    bit idle_gaps = 1'b1;

    always #2 i_clk = ~i_clk;

    bezier_curve_flattener dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_point (o_point)
    );

    // The receiver can never stall, so every strobed point is checked at the
    // edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            board.check_point(o_point);
        end
    end

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 4095)) - 24'd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one request and hold start until a rising edge with busy low takes
    // it. Start stays high across back-to-back transactions unless an idle gap is drawn.
    task automatic send_request(t_bcf_in rq);
        int gap;
        if (idle_gaps && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(rq);
        requests_sent++;
        if (rq.cmd == CMD_CUBIC) cubic_sent++; else quad_sent++;
    endtask

    function automatic t_bcf_in random_request(int mode);
        t_bcf_in rq;
        int r;
        rq.cmd = ($urandom_range(0, 1) == 1) ? CMD_CUBIC : CMD_QUAD;
        rq.start_x = rand_coord(mode); rq.start_y = rand_coord(mode);
        rq.ctrl1_x = rand_coord(mode); rq.ctrl1_y = rand_coord(mode);
        rq.ctrl2_x = rand_coord(mode); rq.ctrl2_y = rand_coord(mode);
        rq.end_x = rand_coord(mode);   rq.end_y = rand_coord(mode);
        // Mostly short curves, with a share of the longest and of zero.
        r = $urandom_range(0, 9);
        if (r == 0) rq.segment_count = 6'd63;
        else if (r == 1) rq.segment_count = 6'd0;
        else rq.segment_count = 6'($urandom_range(1, 16));
        return rq;
    endfunction

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_bcf_in rq;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: both orders, coordinate extremes, zero and maximum
        // segment counts, and junk in ctrl2 on a quadratic request.
        for (int k = 0; k < 16; k++) begin
            rq.cmd = k[0] ? CMD_CUBIC : CMD_QUAD;
            rq.start_x = rand_coord(k[1] ? 0 : 1); rq.start_y = rand_coord(k[1] ? 1 : 0);
            rq.ctrl1_x = rand_coord(k[2] ? 0 : 1); rq.ctrl1_y = rand_coord(k[2] ? 0 : 1);
            rq.ctrl2_x = rand_coord(k[3] ? 0 : 1); rq.ctrl2_y = rand_coord(k[3] ? 1 : 0);
            rq.end_x = rand_coord(k[1] ? 1 : 0);   rq.end_y = rand_coord(k[2] ? 1 : 0);
            case (k % 4)
                0: rq.segment_count = 6'd0;
                1: rq.segment_count = 6'd1;
                2: rq.segment_count = 6'd63;
                default: rq.segment_count = 6'd2;
            endcase
            send_request(rq);
        end
        for (int k = 0; k < 4; k++) begin
            send_request(random_request(3));
        end

        // Hold off until every pending point has come out.
        start <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        // Random part; the last stretch runs without idle gaps.
        for (int k = 0; k < 410; k++) begin
            if (k == 340) idle_gaps = 1'b0;
            send_request(random_request($urandom_range(0, 9) < 6 ? 3 :
                                        $urandom_range(0, 2)));
        end
        start <= 1'b0;

        wait_drained();
        repeat (30) @(posedge i_clk);
        $display("Sent %0d curve requests (%0d quadratic, %0d cubic); checked %0d points.",
                 requests_sent, quad_sent, cubic_sent, board.points_checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Generous bound on the run time of all 430 requests, many times over.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
